@@ design/humidity_temperature_frame_decoder_assert.svh @@
// Assertion macros shared by the frame decoder modules.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef HUMIDITY_TEMPERATURE_FRAME_DECODER_ASSERT_SVH
`define HUMIDITY_TEMPERATURE_FRAME_DECODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HFD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/hfd_pkg.sv @@
`timescale 1ns / 1ps

package hfd_pkg;

  localparam int FRAME_BYTES = 7;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);

  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Status byte bit positions.
  localparam int ST_CAL_BIT  = 3;
  localparam int ST_CRCF_BIT = 4;
  localparam int ST_BUSY_BIT = 7;

  localparam int RAW_W   = 20;
  localparam int HUM_W   = 14;
  localparam int TEMP_W  = 15;

  localparam logic [13:0] HUM_SCALE   = 14'd10000;
  localparam logic [14:0] TEMP_SCALE  = 15'd20000;
  localparam logic [15:0] TEMP_OFFSET = 16'd5000;

  typedef enum logic [1:0] {
    OUTCOME_VALID  = 2'd0,
    OUTCOME_STATUS = 2'd1,
    OUTCOME_CRC    = 2'd2
  } outcome_t;

  // Result of the frame tracker for the byte currently offered to it.
  typedef struct packed {
    logic             last;
    outcome_t         outcome;
    logic [RAW_W-1:0] hum_raw;
    logic [RAW_W-1:0] temp_raw;
  } frame_res_t;

  typedef struct packed {
    logic        [HUM_W-1:0]  hum_centi;
    logic signed [TEMP_W-1:0] temp_centi;
  } scaled_t;

  // One byte of CRC-8, MSB first, no reflection.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

@@ design/hfd_frame_track.sv @@
`timescale 1ns / 1ps

module hfd_frame_track import hfd_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic [7:0]       rx_byte,
  input  logic             frame_start,
  output frame_res_t       res
);

`include "humidity_temperature_frame_decoder_assert.svh"

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       crc_r, crc_nxt;
  logic [7:0]       status_r, status_nxt;
  logic [39:0]      data_r, data_nxt;
  logic [POS_W-1:0] pos;
  logic             ok_status;

  assign pos = frame_start ? '0 : pos_r;
  assign ok_status = status_r[ST_CAL_BIT] & status_r[ST_CRCF_BIT] & ~status_r[ST_BUSY_BIT];

  always_comb begin
    res.last = (pos >= LAST_POS);
    priority if (!ok_status) begin
      res.outcome = OUTCOME_STATUS;
    end else if (crc_r != rx_byte) begin
      res.outcome = OUTCOME_CRC;
    end else begin
      res.outcome = OUTCOME_VALID;
    end
    if (res.outcome == OUTCOME_VALID) begin
      res.hum_raw  = data_r[39:20];
      res.temp_raw = data_r[19:0];
    end else begin
      res.hum_raw  = '0;
      res.temp_raw = '0;
    end
  end

  always_comb begin
    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    status_nxt = status_r;
    data_nxt   = data_r;
    if (en) begin
      if (pos >= LAST_POS) begin
        pos_nxt = '0;
        crc_nxt = CRC_INIT;
      end else begin
        pos_nxt = pos + POS_W'(1);
        if (pos == '0) begin
          status_nxt = rx_byte;
          data_nxt   = '0;
          crc_nxt    = crc8_byte(CRC_INIT, rx_byte);
        end else begin
          data_nxt = {data_r[31:0], rx_byte};
          crc_nxt  = crc8_byte(crc_r, rx_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r    <= '0;
      crc_r    <= CRC_INIT;
      status_r <= '0;
      data_r   <= '0;
    end else begin
      pos_r    <= pos_nxt;
      crc_r    <= crc_nxt;
      status_r <= status_nxt;
      data_r   <= data_nxt;
    end
  end

  `HFD_ASSERT_NOW(a_pos_range, 1'b1, pos_r <= LAST_POS, "byte position out of range")
  `HFD_ASSERT_NEXT(a_last_rewinds, en && res.last, pos_r == '0 && crc_r == CRC_INIT,
                   "frame end did not rewind position and CRC")
  `HFD_ASSERT_NEXT(a_start_advances, en && frame_start, pos_r == POS_W'(1),
                   "status byte did not move to first data byte")

endmodule

@@ design/hfd_scale.sv @@
`timescale 1ns / 1ps

module hfd_scale import hfd_pkg::*; (
  input  frame_res_t res,
  output scaled_t    scaled
);

  logic [RAW_W+HUM_W-1:0]  hum_prod;
  logic [RAW_W+TEMP_W-1:0] temp_prod;
  logic [15:0]             temp_diff;

  assign hum_prod  = res.hum_raw * HUM_SCALE;
  assign temp_prod = res.temp_raw * TEMP_SCALE;
  assign temp_diff = {1'b0, temp_prod[RAW_W+TEMP_W-1:RAW_W]} - TEMP_OFFSET;

  // Refused frames report zero in every value field, the offset included.
  always_comb begin
    if (res.outcome == OUTCOME_VALID) begin
      scaled.hum_centi  = hum_prod[RAW_W+HUM_W-1:RAW_W];
      scaled.temp_centi = signed'(temp_diff[TEMP_W-1:0]);
    end else begin
      scaled.hum_centi  = '0;
      scaled.temp_centi = '0;
    end
  end

endmodule

@@ design/humidity_temperature_frame_decoder.sv @@
`timescale 1ns / 1ps

// Humidity and temperature sensor frame decoder. Feed the seven frame bytes
// (status, five data bytes, CRC) one transfer per byte; frame_start marks the
// status byte and may be raised at any position to drop a partial frame. One
// result transfer follows each seventh byte, carrying an outcome (valid, status
// refused, CRC mismatch), the two 20-bit raw codes and both values in
// hundredths; a refused or mismatched frame reports zero in every value field.
// The block takes one byte every clock cycle as long as the result side keeps
// up. A byte waits in the input register, where the CRC-8 step
// (polynomial 0x31, initial value 0xFF) and the scaling multipliers are
// evaluated, and leaves it when the result register is free; the last byte
// of a frame loads its result into the result register as it leaves.
// A stall on the result channel while a result is offered holds the result
// register and, once the input register is full, stalls the input channel
// in the same cycle.

module humidity_temperature_frame_decoder import hfd_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [7:0]               in_rx_byte,
  input  logic                     in_frame_start,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [1:0]               out_outcome,
  output logic [RAW_W-1:0]         out_humidity_raw,
  output logic [RAW_W-1:0]         out_temperature_raw,
  output logic [HUM_W-1:0]         out_humidity_centi,
  output logic signed [TEMP_W-1:0] out_temperature_centi
);

`include "humidity_temperature_frame_decoder_assert.svh"

  // Input register.
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       s1_start_r;

  // Result register.
  logic                     out_valid_r, out_valid_nxt;
  outcome_t                 out_outcome_r;
  logic [RAW_W-1:0]         out_hum_raw_r;
  logic [RAW_W-1:0]         out_temp_raw_r;
  logic [HUM_W-1:0]         out_hum_centi_r;
  logic signed [TEMP_W-1:0] out_temp_centi_r;

  logic       out_free;
  logic       s1_move;
  logic       in_take;
  frame_res_t res;
  scaled_t    scaled;

  // The result register can take a new value when it is empty or its value
  // transfers in this cycle. The input register drains under the same rule,
  // whether or not its byte closes a frame, which keeps results in order.
  assign out_free = !out_valid_r || !out_stall;
  assign s1_move  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  hfd_frame_track u_track (
    .clk         (clk),
    .rst_n       (rst_n),
    .en          (s1_move),
    .rx_byte     (s1_byte_r),
    .frame_start (s1_start_r),
    .res         (res)
  );

  hfd_scale u_scale (
    .res    (res),
    .scaled (scaled)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = s1_move && res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r  <= in_rx_byte;
      s1_start_r <= in_frame_start;
    end
    if (s1_move && res.last) begin
      out_outcome_r    <= res.outcome;
      out_hum_raw_r    <= res.hum_raw;
      out_temp_raw_r   <= res.temp_raw;
      out_hum_centi_r  <= scaled.hum_centi;
      out_temp_centi_r <= scaled.temp_centi;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_outcome           = out_outcome_r;
  assign out_humidity_raw      = out_hum_raw_r;
  assign out_temperature_raw   = out_temp_raw_r;
  assign out_humidity_centi    = out_hum_centi_r;
  assign out_temperature_centi = out_temp_centi_r;

  `HFD_ASSERT_NOW(a_stall_needs_item, in_stall, s1_valid_r,
                  "input stalled with an empty input register")
  `HFD_ASSERT_NEXT(a_frame_end_gives_result, s1_move && res.last, out_valid_r,
                   "frame end did not load the result register")
  `HFD_ASSERT_NOW(a_refused_fields_zero,
                  out_valid_r && out_outcome_r != OUTCOME_VALID,
                  out_hum_raw_r == '0 && out_temp_raw_r == '0 &&
                  out_hum_centi_r == '0 && out_temp_centi_r == '0,
                  "refused frame carries nonzero value fields")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Testbench for the humidity and temperature frame decoder.
//
// Bytes go in through a sender task that works in bursts with random gaps. A
// monitor on the input channel feeds every accepted byte to a cycle-free model
// of the frame decoder, and that model queues the result a completed frame must
// produce. A second monitor on the result channel compares every result
// transfer with the oldest queued result, field by field. The receiver stalls
// on a pattern chosen per test, and it can hold off for a long, counted
// stretch so that the block fills up and stalls its input.
//
// The tests run in turn: a short directed set of frames, random traffic under
// several gap and stall patterns, and a long result hold-off. Between tests the
// sender waits until every queued result has come back.

module tb_top;
  import hfd_pkg::*;

  // A run far slower than any correct one; reaching it means the block hung.
  localparam int CYCLE_LIMIT = 200_000;
  // Margin the sender waits after the last queued result has come back.
  localparam int DRAIN_CYCLES = 6;
  localparam int HOLD_OFF_CYCLES = 80;

  // Receiver behavior on the result channel.
  typedef enum int {
    RX_READY,
    RX_LIGHT,
    RX_HEAVY,
    RX_PERIODIC
  } rx_pattern_t;

  // How the status byte of a generated frame is built.
  typedef enum int {
    STATUS_GOOD,
    STATUS_UNCAL,
    STATUS_NO_CRC_FLAG,
    STATUS_BUSY,
    STATUS_ANY
  } status_kind_t;

  // One decoded frame as the result channel should present it.
  typedef struct {
    outcome_t                 outcome;
    logic [RAW_W-1:0]         hum_raw;
    logic [RAW_W-1:0]         temp_raw;
    logic [HUM_W-1:0]         hum_centi;
    logic signed [TEMP_W-1:0] temp_centi;
  } decoded_frame_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [7:0]               in_rx_byte = 8'h00;
  logic                     in_frame_start = 1'b0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [1:0]               out_outcome;
  logic [RAW_W-1:0]         out_humidity_raw;
  logic [RAW_W-1:0]         out_temperature_raw;
  logic [HUM_W-1:0]         out_humidity_centi;
  logic signed [TEMP_W-1:0] out_temperature_centi;

  // Frame tracking state of the model, mirroring what the block holds.
  logic [POS_W-1:0] frame_pos    = '0;
  logic [7:0]       frame_crc    = CRC_INIT;
  logic [7:0]       frame_status = 8'h00;
  logic [39:0]      frame_data   = '0;

  decoded_frame_t pending_frames[$];

  int          fail_count      = 0;
  int          cycle_count     = 0;
  int          bytes_sent      = 0;
  int          burst_left      = 0;
  int          gap_max         = 0;
  int          hold_off_cycles = 0;
  rx_pattern_t rx_pattern      = RX_READY;

  humidity_temperature_frame_decoder dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_rx_byte            (in_rx_byte),
    .in_frame_start        (in_frame_start),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_outcome           (out_outcome),
    .out_humidity_raw      (out_humidity_raw),
    .out_temperature_raw   (out_temperature_raw),
    .out_humidity_centi    (out_humidity_centi),
    .out_temperature_centi (out_temperature_centi)
  );

  always #5 clk = ~clk;

  // The watchdog counts every cycle of the run, reset included.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // One CRC-8 step over a byte, most significant bit first. Each shift feeds
  // the polynomial back in whenever a one falls out of the top.
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] r;
    r = crc ^ b;
    repeat (8) r = {r[6:0], 1'b0} ^ (r[7] ? CRC_POLY : 8'h00);
    return r;
  endfunction

  // Model of the decoder for one accepted byte. A byte that lands on the last
  // position of a frame closes it and queues exactly one result. The status
  // check wins over the CRC check, and any refused frame reports zeros in all
  // value fields. Both scalings truncate before the temperature offset.
  task automatic decode_byte(input logic [7:0] b, input logic start);
    logic [POS_W-1:0]  pos;
    logic              status_ok;
    logic [RAW_W+13:0] hum_product;
    logic [RAW_W+14:0] temp_product;
    int                temp_value;
    decoded_frame_t    res;
    pos = start ? '0 : frame_pos;
    if (pos >= LAST_POS) begin
      res.outcome    = OUTCOME_VALID;
      res.hum_raw    = '0;
      res.temp_raw   = '0;
      res.hum_centi  = '0;
      res.temp_centi = '0;
      status_ok = frame_status[ST_CAL_BIT] && frame_status[ST_CRCF_BIT] &&
                  !frame_status[ST_BUSY_BIT];
      if (!status_ok) begin
        res.outcome = OUTCOME_STATUS;
      end else if (frame_crc != b) begin
        res.outcome = OUTCOME_CRC;
      end else begin
        res.hum_raw    = frame_data[2*RAW_W-1:RAW_W];
        res.temp_raw   = frame_data[RAW_W-1:0];
        hum_product    = res.hum_raw * HUM_SCALE;
        temp_product   = res.temp_raw * TEMP_SCALE;
        res.hum_centi  = hum_product[RAW_W+13:RAW_W];
        temp_value     = int'(temp_product[RAW_W+14:RAW_W]) - int'(TEMP_OFFSET);
        res.temp_centi = TEMP_W'(temp_value);
      end
      pending_frames.push_back(res);
      frame_pos = '0;
      frame_crc = CRC_INIT;
    end else if (pos == '0) begin
      // A status byte restarts the frame, whatever was collected before.
      frame_status = b;
      frame_data   = '0;
      frame_crc    = crc8_step(CRC_INIT, b);
      frame_pos    = POS_W'(1);
    end else begin
      frame_data = {frame_data[31:0], b};
      frame_crc  = crc8_step(frame_crc, b);
      frame_pos  = pos + 1'b1;
    end
  endtask

  // Every input transfer goes through the model at the edge that accepts it.
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      decode_byte(in_rx_byte, in_frame_start);
    end
  end

  // Result checker: each result transfer must match the oldest queued frame.
  always @(posedge clk) begin : check_results
    decoded_frame_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_frames.size() == 0) begin
        $error("result transfer with no frame waiting for it: outcome %0d", out_outcome);
        fail_count++;
      end else begin
        want = pending_frames.pop_front();
        if (out_outcome !== want.outcome) begin
          $error("outcome: expected %0d, got %0d", want.outcome, out_outcome);
          fail_count++;
        end
        if (out_humidity_raw !== want.hum_raw) begin
          $error("humidity_raw: expected %0d, got %0d", want.hum_raw, out_humidity_raw);
          fail_count++;
        end
        if (out_temperature_raw !== want.temp_raw) begin
          $error("temperature_raw: expected %0d, got %0d", want.temp_raw,
                 out_temperature_raw);
          fail_count++;
        end
        if (out_humidity_centi !== want.hum_centi) begin
          $error("humidity_centi: expected %0d, got %0d", want.hum_centi,
                 out_humidity_centi);
          fail_count++;
        end
        if (out_temperature_centi !== want.temp_centi) begin
          $error("temperature_centi: expected %0d, got %0d", want.temp_centi,
                 out_temperature_centi);
          fail_count++;
        end
      end
    end
  end

  // The receiver. A requested hold-off takes priority and is counted down
  // here; otherwise the stall follows the pattern the current test selected.
  always @(posedge clk) begin
    if (hold_off_cycles > 0) begin
      hold_off_cycles = hold_off_cycles - 1;
      out_stall <= 1'b1;
    end else begin
      case (rx_pattern)
        RX_READY:    out_stall <= 1'b0;
        RX_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        RX_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        RX_PERIODIC: out_stall <= ((cycle_count % 9) < 4);
        default:     out_stall <= 1'b0;
      endcase
    end
  end

  // Sends one byte and returns at the edge of its transfer. Bursts of random
  // length are separated by random gaps no longer than gap_max.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_rx_byte     <= b;
    in_frame_start <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    bytes_sent++;
  endtask

  // Sends a whole frame with a CRC computed over status and data. A corrupted
  // frame gets its CRC byte flipped in at least one bit.
  task automatic send_frame(input logic [7:0] status, input logic [39:0] data,
                            input logic corrupt, input logic start);
    logic [7:0] crc;
    crc = crc8_step(CRC_INIT, status);
    for (int i = 4; i >= 0; i--) crc = crc8_step(crc, data[i*8 +: 8]);
    if (corrupt) crc = crc ^ 8'($urandom_range(1, 255));
    send_byte(status, start);
    for (int i = 4; i >= 0; i--) send_byte(data[i*8 +: 8], 1'b0);
    send_byte(crc, 1'b0);
  endtask

  // Data bytes lean toward all zeros and all ones so that the raw codes hit
  // both ends of their range now and then.
  function automatic logic [7:0] rand_data_byte();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [7:0] pick_status(input status_kind_t kind);
    logic [7:0] s;
    s = 8'($urandom);
    case (kind)
      STATUS_GOOD: begin
        s[ST_CAL_BIT]  = 1'b1;
        s[ST_CRCF_BIT] = 1'b1;
        s[ST_BUSY_BIT] = 1'b0;
      end
      STATUS_UNCAL:       s[ST_CAL_BIT]  = 1'b0;
      STATUS_NO_CRC_FLAG: s[ST_CRCF_BIT] = 1'b0;
      STATUS_BUSY:        s[ST_BUSY_BIT] = 1'b1;
      default: ;
    endcase
    return s;
  endfunction

  // The sender stops and waits until every queued result has come back, then
  // waits out the DRAIN_CYCLES margin in case something unexpected is still coming.
  task automatic wait_results_done();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_frames.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Directed frames: the largest and smallest codes with a clean CRC, a frame
  // that follows the previous one without a start mark, a partial frame
  // dropped by a resync, and a busy status on a frame whose CRC is also wrong,
  // which must be reported as a status refusal.
  task automatic test_directed_frames();
    gap_max    = 0;
    rx_pattern = RX_READY;
    send_frame(8'h18, 40'hFF_FFFF_FFFF, 1'b0, 1'b1);
    send_frame(8'h18, 40'h00_0000_0000, 1'b0, 1'b0);
    send_byte(8'h1C, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_frame(8'h98, 40'h00_0000_0000, 1'b1, 1'b1);
    wait_results_done();
  endtask

  // Random traffic. Most of it is well-formed frames with random content, a
  // part of them with a broken CRC; the rest is frames with mostly refused status
  // bytes, partial frames cut off by a resync, and loose bytes with random start marks.
  task automatic test_random_traffic(input int n_bytes, input int max_gap,
                                     input rx_pattern_t pattern);
    int          target;
    int          pick;
    logic        need_start;
    logic [39:0] data;
    gap_max    = max_gap;
    rx_pattern = pattern;
    need_start = 1'b1;
    target     = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      data = {rand_data_byte(), rand_data_byte(), rand_data_byte(),
              rand_data_byte(), rand_data_byte()};
      if (pick < 70) begin
        send_frame(pick_status(STATUS_GOOD), data, $urandom_range(0, 9) == 0,
                   need_start || ($urandom_range(0, 1) == 1));
        need_start = 1'b0;
      end else if (pick < 85) begin
        send_frame(pick_status(status_kind_t'($urandom_range(STATUS_UNCAL, STATUS_ANY))),
                   data, $urandom_range(0, 1) == 1,
                   need_start || ($urandom_range(0, 1) == 1));
        need_start = 1'b0;
      end else if (pick < 93) begin
        // The frame is cut short; the next one must carry a start mark.
        send_byte(pick_status(STATUS_GOOD), 1'b1);
        repeat ($urandom_range(1, 5)) send_byte(rand_data_byte(), 1'b0);
        need_start = 1'b1;
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom), $urandom_range(0, 1) == 1);
        need_start = 1'b1;
      end
    end
    wait_results_done();
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // good frames back to back, so the result and input registers fill and the
  // input channel has to stall until the hold-off ends.
  task automatic test_output_hold_off();
    gap_max         = 0;
    burst_left      = 0;
    rx_pattern      = RX_READY;
    hold_off_cycles = HOLD_OFF_CYCLES;
    repeat (6) begin
      send_frame(pick_status(STATUS_GOOD),
                 {rand_data_byte(), rand_data_byte(), rand_data_byte(),
                  rand_data_byte(), rand_data_byte()}, 1'b0, 1'b1);
    end
    wait_results_done();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_frames();
    test_random_traffic(180, 0, RX_READY);
    test_random_traffic(180, 6, RX_LIGHT);
    test_random_traffic(180, 2, RX_HEAVY);
    test_random_traffic(180, 4, RX_PERIODIC);
    test_output_hold_off();

    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+design
design/hfd_pkg.sv
design/hfd_frame_track.sv
design/hfd_scale.sv
design/humidity_temperature_frame_decoder.sv
tb/tb_top.sv
